// ===== src/pfxev_pkg.sv =====
// ----------------------------------------------------------------------------
// Postfix evaluator package
// Shared types, character codes and the symbol decoder used by the
// controller and the datapath of the postfix expression evaluator.
// ----------------------------------------------------------------------------
package pfxev_pkg;

   // Width of an operand and of the result value.
   localparam int DATA_W    = 32;
   localparam int DIV_CNT_W = $clog2(DATA_W);

   // ASCII codes that the evaluator recognizes.
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;

   // Completion codes reported with each result.
   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_UNDERFLOW = 3'd1,
      ST_DIVZERO   = 3'd2,
      ST_UNKNOWN   = 3'd3,
      ST_OVERFLOW  = 3'd4,
      ST_EMPTY     = 3'd5
   } status_type;

   // Class of an incoming character.
   typedef enum logic [2:0] {
      SC_SPACE,
      SC_DIGIT,
      SC_ADD,
      SC_SUB,
      SC_MUL,
      SC_DIV,
      SC_OTHER
   } sym_class_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic          push;
      logic          set_err;
      status_type    err_code;
      logic          emit;
      logic          div_start;
      logic          commit;
      sym_class_type op;
   } pfxev_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      sym_class_type sym_class;
      logic          err_active;
      logic          sp_lt2;
      logic          sp_full;
      logic          tos_zero;
      logic          div_busy;
      logic          div_done;
   } pfxev_stat_type;

   // Sort a character into its class.
   function automatic sym_class_type classify(input logic [7:0] c);
      sym_class_type cls;
      priority if (c == CH_SPACE)                 cls = SC_SPACE;
      else if (c >= CH_ZERO && c <= CH_NINE)      cls = SC_DIGIT;
      else if (c == CH_PLUS)                      cls = SC_ADD;
      else if (c == CH_MINUS)                     cls = SC_SUB;
      else if (c == CH_STAR)                      cls = SC_MUL;
      else if (c == CH_SLASH)                     cls = SC_DIV;
      else                                        cls = SC_OTHER;
      return cls;
   endfunction

endpackage

// ===== src/postfix_expression_evaluator_core.sv =====
// Space, digit, error and end characters are handled in the idle state; + - *
// also pass through the execute state, and / then waits in the bit-serial divider.
// No new character is taken until the previous one is finished; / takes longest.
// A result is presented the cycle after its end item is transferred.
// Reset clears the stack pointer, the error latch and the result valid flag;
// stack entries are undefined until written and need no clearing pass.
// ----------------------------------------------------------------------------
// Postfix expression evaluator core
// Evaluates an ASCII postfix expression one character per transfer and
// returns the value and a status code on each end item.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_core #(
   parameter int STACK_DEPTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_symbol,
   input  logic               req_end_marker,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_value,
   output logic [2:0]         rsp_status
);
   import pfxev_pkg::*;

   pfxev_cmd_type  cmd;
   pfxev_stat_type stat;

   pfxev_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_end_marker (req_end_marker),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .stat           (stat),
      .cmd            (cmd)
   );

   pfxev_dpath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_symbol (req_symbol),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status)
   );

   // An end item always yields a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_end_marker) |=> rsp_valid)
      else $error("end item did not produce a result");

   // Other items never create a result.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_end_marker && !rsp_valid) |=> !rsp_valid)
      else $error("result appeared without an end item");

   // Any nonzero status carries a zero value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_value == '0))
      else $error("error result with nonzero value");

   // No character is taken while the divider runs.
   assert property (@(posedge clock) disable iff (reset)
      stat.div_busy |-> !req_ready)
      else $error("input accepted during division");

endmodule

// ===== src/pfxev_div.sv =====
// ----------------------------------------------------------------------------
// Postfix evaluator divider
// Restoring signed divider, one quotient bit per cycle, truncating toward
// zero with two's complement wrap of the quotient.
// ----------------------------------------------------------------------------
module pfxev_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        busy,
   output logic        done,
   output logic [31:0] quotient
);
   import pfxev_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DATA_W-1:0]    rem_ff, rem_in;
   logic [DATA_W-1:0]    quo_ff, quo_in;
   logic [DATA_W-1:0]    dsr_ff, dsr_in;
   logic                 neg_ff, neg_in;
   logic [DATA_W:0]      shifted;
   logic [DATA_W:0]      diff;
   logic [DATA_W-1:0]    lmag;
   logic [DATA_W-1:0]    rmag;

   // Operand magnitudes and one trial subtraction per cycle.
   always_comb begin
      lmag    = dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
      rmag    = divisor[DATA_W-1]  ? (DATA_W'(0) - divisor)  : divisor;
      shifted = {rem_ff, quo_ff[DATA_W-1]};
      diff    = shifted - {1'b0, dsr_ff};
   end

   // Iteration control.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = lmag;
         dsr_in  = rmag;
         neg_in  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
      end else if (busy_ff) begin
         rem_in = diff[DATA_W] ? shifted[DATA_W-1:0] : diff[DATA_W-1:0];
         quo_in = {quo_ff[DATA_W-2:0], ~diff[DATA_W]};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      neg_ff <= neg_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = neg_ff ? (DATA_W'(0) - quo_ff) : quo_ff;

endmodule

// ===== src/pfxev_dpath.sv =====
// ----------------------------------------------------------------------------
// Postfix evaluator datapath
// Operand stack with the top entry held in a register, stack pointer,
// error latch, arithmetic unit, divider and the result register.
// ----------------------------------------------------------------------------
module pfxev_dpath #(
   parameter int STACK_DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [7:0]               req_symbol,
   input  pfxev_pkg::pfxev_cmd_type cmd,
   output pfxev_pkg::pfxev_stat_type stat,
   output logic signed [31:0]       rsp_value,
   output logic [2:0]               rsp_status
);
   import pfxev_pkg::*;

   localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int SPW = $clog2(STACK_DEPTH + 1);

   // Entries below the top of stack; the top lives in tos_ff.
   logic [DATA_W-1:0] stack_mem_ff [STACK_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;
   logic [DATA_W-1:0] tos_ff, tos_in;
   logic [SPW-1:0]    sp_ff, sp_in;
   status_type        err_ff, err_in;
   logic [DATA_W-1:0] value_ff, value_in;
   status_type        status_ff, status_in;
   logic [SPW-1:0]    sp_dec;
   logic [SPW-1:0]    sp_dec2;
   logic [AW-1:0]     wr_addr;
   logic [AW-1:0]     rd_addr;
   logic [7:0]        digit;
   logic [DATA_W-1:0] alu_res;
   logic [DATA_W-1:0] div_q;
   logic              div_busy;
   logic              div_done;

   assign sp_dec  = sp_ff - SPW'(1);
   assign sp_dec2 = sp_ff - SPW'(2);
   assign wr_addr = sp_dec[AW-1:0];
   assign rd_addr = sp_dec2[AW-1:0];
   assign digit   = req_symbol - CH_ZERO;

   // Second entry from the top is read into a register for the operators.
   always_ff @(posedge clock) begin
      rd_data_ff <= stack_mem_ff[rd_addr];
      if (cmd.push && sp_ff != '0) begin
         stack_mem_ff[wr_addr] <= tos_ff;
      end
   end

   pfxev_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (rd_data_ff),
      .divisor  (tos_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q)
   );

   // Result of the operator: left operand from memory, right from the top.
   always_comb begin
      unique case (cmd.op)
         SC_ADD:  alu_res = rd_data_ff + tos_ff;
         SC_SUB:  alu_res = rd_data_ff - tos_ff;
         SC_MUL:  alu_res = rd_data_ff * tos_ff;
         SC_DIV:  alu_res = div_q;
         default: alu_res = tos_ff;
      endcase
   end

   // Stack pointer, top of stack, error latch and result register.
   always_comb begin
      tos_in    = tos_ff;
      sp_in     = sp_ff;
      err_in    = err_ff;
      value_in  = value_ff;
      status_in = status_ff;
      if (cmd.push) begin
         tos_in = {{(DATA_W-8){1'b0}}, digit};
         sp_in  = sp_ff + SPW'(1);
      end
      if (cmd.commit) begin
         tos_in = alu_res;
         sp_in  = sp_dec;
      end
      if (cmd.set_err) begin
         err_in = cmd.err_code;
      end
      if (cmd.emit) begin
         if (err_ff != ST_OK) begin
            status_in = err_ff;
            value_in  = '0;
         end else if (sp_ff == '0) begin
            status_in = ST_EMPTY;
            value_in  = '0;
         end else begin
            status_in = ST_OK;
            value_in  = tos_ff;
         end
         sp_in  = '0;
         err_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff  <= '0;
         err_ff <= ST_OK;
      end else begin
         sp_ff  <= sp_in;
         err_ff <= err_in;
      end
      tos_ff    <= tos_in;
      value_ff  <= value_in;
      status_ff <= status_in;
   end

   // Status toward the controller.
   always_comb begin
      stat.sym_class  = classify(req_symbol);
      stat.err_active = (err_ff != ST_OK);
      stat.sp_lt2     = (sp_ff < SPW'(2));
      stat.sp_full    = (sp_ff == SPW'(STACK_DEPTH));
      stat.tos_zero   = (tos_ff == '0);
      stat.div_busy   = div_busy;
      stat.div_done   = div_done;
   end

   assign rsp_value  = value_ff;
   assign rsp_status = status_ff;

endmodule

// ===== src/pfxev_ctrl.sv =====
// ----------------------------------------------------------------------------
// Postfix evaluator controller
// Accepts characters, decides push, operator or error, sequences the
// arithmetic and the divider, and owns the result valid flag.
// ----------------------------------------------------------------------------
module pfxev_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_end_marker,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  pfxev_pkg::pfxev_stat_type stat,
   output pfxev_pkg::pfxev_cmd_type  cmd
);
   import pfxev_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_DIVW
   } state_type;

   state_type     state_ff, state_in;
   sym_class_type op_ff, op_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept;

   // A result waiting at the output only holds back the next end item.
   assign req_ready = (state_ff == S_IDLE) &&
                      (!rsp_valid_ff || rsp_ready || !req_end_marker);
   assign accept    = req_valid && req_ready;

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.err_code = ST_OK;
      cmd.op       = op_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_end_marker) begin
                  cmd.emit     = 1'b1;
                  rsp_valid_in = 1'b1;
               end else if (!stat.err_active) begin
                  if (stat.sym_class == SC_SPACE) begin
                     // Spaces change nothing.
                  end else if (stat.sym_class == SC_DIGIT) begin
                     if (stat.sp_full) begin
                        cmd.set_err  = 1'b1;
                        cmd.err_code = ST_OVERFLOW;
                     end else begin
                        cmd.push = 1'b1;
                     end
                  end else if (stat.sp_lt2) begin
                     cmd.set_err  = 1'b1;
                     cmd.err_code = ST_UNDERFLOW;
                  end else if (stat.sym_class == SC_OTHER) begin
                     cmd.set_err  = 1'b1;
                     cmd.err_code = ST_UNKNOWN;
                  end else if (stat.sym_class == SC_DIV && stat.tos_zero) begin
                     cmd.set_err  = 1'b1;
                     cmd.err_code = ST_DIVZERO;
                  end else begin
                     op_in    = stat.sym_class;
                     state_in = S_EXEC;
                  end
               end
            end
         end
         S_EXEC: begin
            // Left operand is now in the read register.
            if (op_ff == SC_DIV) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIVW;
            end else begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_DIVW: begin
            if (stat.div_done) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= SC_SPACE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
